// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and defaults for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT         = 16;
    localparam int PRIORITY_BITS_DEFAULT = 16;

    // Field widths of the stream payload, fixed by the interface.
    localparam int PRIO_PORT_BITS = 16;
    localparam int TAG_BITS       = 32;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } spq_cmd_t;

    // Operation broadcast to every cell in the chain for one cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } spq_ctrl_t;

endpackage

// ===== rtl/core/stable_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded, stable, lowest-number-first priority queue built as a cell chain.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries in a chain of cells kept in service
// order, the head in cell 0. Each input transaction is one command: a push
// places the entry after every entry of lower or equal priority, so equal
// priorities leave in arrival order; a pop removes the head and is ignored
// on an empty queue; a push on a full queue is dropped and flagged. Every
// cell compares its own priority with the pushed one in parallel and either
// keeps its entry, takes its left neighbour's, takes the new entry, or on a
// pop takes its right neighbour's, so one command is taken every clock
// cycle unless a waiting result is stalled, and its result transaction
// appears in the cycle after acceptance. The result stays in an output
// register until taken; a new command is taken in the same cycle that the
// waiting result leaves. After reset the queue is empty and ready at once.
// ----------------------------------------------------------------------------
module stable_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEFAULT,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] priority_req, [47:16] item_tag
    input  logic [0:0]  s_tuser,   // [0] command
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] head_tag, [47:32] head_priority
    output logic [1:0]  m_tuser    // [0] is_empty, [1] push_dropped
);

    logic                     accept;
    spq_cmd_t                 cmd;
    logic                     full;
    logic                     empty;
    spq_ctrl_t                ctrl;
    logic [PRIORITY_BITS-1:0] new_prio;
    logic [TAG_BITS-1:0]      new_tag;
    logic [PRIO_PORT_BITS-1:0] head_prio_port;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     dropped_reg;
    logic                     dropped_next;

    logic [DEPTH-1:0]         cell_valid;
    logic [DEPTH-1:0]         cell_move;
    logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];
    logic [TAG_BITS-1:0]      cell_tag  [DEPTH];

    assign cmd      = spq_cmd_t'(s_tuser[0]);
    assign new_tag  = s_tdata[47:16];
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = cell_valid[DEPTH-1];
    assign empty    = !cell_valid[0];

    // Only the low PRIORITY_BITS of the requested priority are kept; the
    // head priority is zero-extended or truncated to the port width.
    assign new_prio       = PRIORITY_BITS'(s_tdata[PRIO_PORT_BITS-1:0]);
    assign head_prio_port = PRIO_PORT_BITS'(cell_prio[0]);

    always_comb
    begin
        ctrl.push    = accept && (cmd == CMD_PUSH) && !full;
        ctrl.pop     = accept && (cmd == CMD_POP) && !empty;
        dropped_next = dropped_reg;
        if (accept)
        begin
            dropped_next = (cmd == CMD_PUSH) && full;
        end
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dropped_reg <= dropped_next;
    end

    // The chain. Cell 0 sees a left neighbour that never moves, so a push
    // that reaches it writes the new entry there; the last cell sees an
    // empty right neighbour, so a pop empties it.
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                     lv;
            logic                     lm;
            logic [PRIORITY_BITS-1:0] lp;
            logic [TAG_BITS-1:0]      lt;
            logic                     rv;
            logic [PRIORITY_BITS-1:0] rp;
            logic [TAG_BITS-1:0]      rt;

            if (i == 0)
            begin : g_first
                assign lv = 1'b1;
                assign lm = 1'b0;
                assign lp = new_prio;
                assign lt = new_tag;
            end
            else
            begin : g_inner_left
                assign lv = cell_valid[i-1];
                assign lm = cell_move[i-1];
                assign lp = cell_prio[i-1];
                assign lt = cell_tag[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign rv = 1'b0;
                assign rp = cell_prio[i];
                assign rt = cell_tag[i];
            end
            else
            begin : g_inner_right
                assign rv = cell_valid[i+1];
                assign rp = cell_prio[i+1];
                assign rt = cell_tag[i+1];
            end

            spq_cell #(
                .PRIORITY_BITS(PRIORITY_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_prio   (new_prio),
                .new_tag    (new_tag),
                .left_valid (lv),
                .left_move  (lm),
                .left_prio  (lp),
                .left_tag   (lt),
                .right_valid(rv),
                .right_prio (rp),
                .right_tag  (rt),
                .valid      (cell_valid[i]),
                .move       (cell_move[i]),
                .prio       (cell_prio[i]),
                .tag        (cell_tag[i])
            );
        end
    endgenerate

    // The head cell holds the state after the last accepted command; it
    // cannot change while a result waits, since no command is taken then.
    assign m_tvalid      = out_valid_reg;
    assign m_tdata[31:0]  = empty ? '0 : cell_tag[0];
    assign m_tdata[47:32] = empty ? '0 : head_prio_port;
    assign m_tuser[0]     = empty;
    assign m_tuser[1]     = dropped_reg;

endmodule

// ===== rtl/core/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and trades it with neighbours.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  spq_ctrl_t                ctrl,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic [TAG_BITS-1:0]      new_tag,
    input  logic                     left_valid,
    input  logic                     left_move,
    input  logic [PRIORITY_BITS-1:0] left_prio,
    input  logic [TAG_BITS-1:0]      left_tag,
    input  logic                     right_valid,
    input  logic [PRIORITY_BITS-1:0] right_prio,
    input  logic [TAG_BITS-1:0]      right_tag,
    output logic                     valid,
    output logic                     move,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic [TAG_BITS-1:0]      tag
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;
    logic [TAG_BITS-1:0]      tag_reg;
    logic [TAG_BITS-1:0]      tag_next;

    // The new entry goes behind every entry of lower or equal priority.
    assign move = !valid_reg || (prio_reg > new_prio);

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        tag_next   = tag_reg;
        if (ctrl.push && move)
        begin
            valid_next = valid_reg || left_valid;
            if (left_move)
            begin
                prio_next = left_prio;
                tag_next  = left_tag;
            end
            else
            begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next = right_valid;
            prio_next  = right_prio;
            tag_next   = right_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

    assign valid = valid_reg;
    assign prio  = prio_reg;
    assign tag   = tag_reg;

endmodule
